[rtl/nearest_palette_color_assert.svh]
// assertion macros for the nearest palette color block
`ifndef NEAREST_PALETTE_COLOR_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_ASSERT_SVH

// same-cycle implication
`define NPC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication
`define NPC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/npc_pkg.sv]
// shared types, constants and helpers of the nearest palette color block
package npc_pkg;

    localparam int PALETTE_SIZE = 16;
    localparam int PAL_IDX_W    = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
    localparam int IDX_W        = 4;
    localparam int CH_W         = 8;
    localparam int SQ_W         = 2 * CH_W;
    localparam int DIST_W       = SQ_W + 2;

    typedef enum logic {
        REQ_LOAD  = 1'b0,
        REQ_QUERY = 1'b1
    } req_kind_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic             is_query;
        logic [IDX_W-1:0] slot;
        color_t           color;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } q_head_t;

    typedef struct packed {
        logic busy;
        logic emitting;
    } back_status_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

[rtl/npc_req_if.sv]
// request channel: palette loads and color queries
interface npc_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [npc_pkg::IDX_W-1:0]  entry_index;
    logic [npc_pkg::CH_W-1:0]   red;
    logic [npc_pkg::CH_W-1:0]   green;
    logic [npc_pkg::CH_W-1:0]   blue;

    modport source (output valid, req_type, entry_index, red, green, blue, input ready);
    modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

[rtl/npc_rsp_if.sv]
// response channel: nearest palette entry
interface npc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [npc_pkg::IDX_W-1:0]  nearest_index;
    logic [npc_pkg::CH_W-1:0]   match_red;
    logic [npc_pkg::CH_W-1:0]   match_green;
    logic [npc_pkg::CH_W-1:0]   match_blue;

    modport source (output valid, nearest_index, match_red, match_green, match_blue,
                    input ready);
    modport sink   (input valid, nearest_index, match_red, match_green, match_blue,
                    output ready);
endinterface

[rtl/npc_front.sv]
// front end: accepts request beats, classifies them and queues them for the back end
module npc_front (
    input  logic                clk,
    input  logic                rst_n,
    npc_req_if.sink             req,
    output npc_pkg::q_head_t    head,
    input  logic                pop
);

    npc_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    npc_pkg::item_t item_in;
    logic           accept;
    logic           keep;
    logic           push;

    assign req.ready = (count_reg != 2'd2);
    assign accept    = req.valid && req.ready;

    // loads aimed past the palette are dropped here
    always_comb
    begin
        item_in.is_query    = (req.req_type == npc_pkg::REQ_QUERY);
        item_in.slot        = req.entry_index;
        item_in.color.red   = req.red;
        item_in.color.green = req.green;
        item_in.color.blue  = req.blue;
        keep = item_in.is_query || (32'(req.entry_index) < npc_pkg::PALETTE_SIZE);
    end

    assign push = accept && keep;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

[rtl/npc_back.sv]
// back end: palette store, serial distance scan and result register
module npc_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  npc_pkg::q_head_t        head,
    output logic                    pop,
    output npc_pkg::back_status_t   status,
    npc_rsp_if.source               rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_SCAN = 4'b0010,
        ST_LAST = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    npc_pkg::color_t                    palette_reg [npc_pkg::PALETTE_SIZE];
    npc_pkg::color_t                    query_reg;
    logic [npc_pkg::PAL_IDX_W-1:0]      cnt_reg;
    logic [npc_pkg::PAL_IDX_W-1:0]      cnt_next;

    logic                               s1_valid_reg;
    logic [npc_pkg::PAL_IDX_W-1:0]      s1_idx_reg;
    npc_pkg::color_t                    s1_color_reg;
    logic [npc_pkg::SQ_W-1:0]           sq_r_reg;
    logic [npc_pkg::SQ_W-1:0]           sq_g_reg;
    logic [npc_pkg::SQ_W-1:0]           sq_b_reg;

    logic [npc_pkg::DIST_W-1:0]         best_dist_reg;
    logic [npc_pkg::PAL_IDX_W-1:0]      best_idx_reg;
    npc_pkg::color_t                    best_color_reg;

    logic                               out_valid_reg;
    logic [npc_pkg::IDX_W-1:0]          out_idx_reg;
    npc_pkg::color_t                    out_color_reg;

    npc_pkg::color_t                    entry;
    logic [npc_pkg::CH_W-1:0]           d_r;
    logic [npc_pkg::CH_W-1:0]           d_g;
    logic [npc_pkg::CH_W-1:0]           d_b;
    logic [npc_pkg::DIST_W-1:0]         dist_sum;
    logic                               take;
    logic                               scanning;
    logic                               load_wr;
    logic                               out_free;
    logic                               emit;
    logic                               cnt_last;

    localparam logic [npc_pkg::PAL_IDX_W-1:0] CNT_LAST =
        npc_pkg::PAL_IDX_W'(npc_pkg::PALETTE_SIZE - 1);

    assign out_free = !out_valid_reg || rsp.ready;
    assign pop      = (state_reg == ST_IDLE) && head.valid;
    assign load_wr  = pop && !head.item.is_query;
    assign scanning = (state_reg == ST_SCAN);
    assign cnt_last = (cnt_reg == CNT_LAST);
    assign emit     = (state_reg == ST_EMIT) && out_free;

    assign status.busy     = (state_reg != ST_IDLE);
    assign status.emitting = emit;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (pop && head.item.is_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + npc_pkg::PAL_IDX_W'(1);
                if (cnt_last)
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // palette store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < npc_pkg::PALETTE_SIZE; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (load_wr)
        begin
            palette_reg[npc_pkg::PAL_IDX_W'(head.item.slot)] <= head.item.color;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.item.is_query)
        begin
            query_reg <= head.item.color;
        end
    end

    // stage one: per-channel difference and square
    assign entry = palette_reg[cnt_reg];
    assign d_r   = npc_pkg::abs_diff(query_reg.red, entry.red);
    assign d_g   = npc_pkg::abs_diff(query_reg.green, entry.green);
    assign d_b   = npc_pkg::abs_diff(query_reg.blue, entry.blue);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= scanning;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scanning)
        begin
            s1_idx_reg   <= cnt_reg;
            s1_color_reg <= entry;
            sq_r_reg     <= npc_pkg::SQ_W'(d_r) * npc_pkg::SQ_W'(d_r);
            sq_g_reg     <= npc_pkg::SQ_W'(d_g) * npc_pkg::SQ_W'(d_g);
            sq_b_reg     <= npc_pkg::SQ_W'(d_b) * npc_pkg::SQ_W'(d_b);
        end
    end

    // stage two: sum and strict compare, first entry always taken
    assign dist_sum = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                    + npc_pkg::DIST_W'(sq_b_reg);
    assign take = s1_valid_reg && ((s1_idx_reg == '0) || (dist_sum < best_dist_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_dist_reg  <= dist_sum;
            best_idx_reg   <= s1_idx_reg;
            best_color_reg <= s1_color_reg;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_idx_reg   <= npc_pkg::IDX_W'(best_idx_reg);
            out_color_reg <= best_color_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.nearest_index = out_idx_reg;
    assign rsp.match_red     = out_color_reg.red;
    assign rsp.match_green   = out_color_reg.green;
    assign rsp.match_blue    = out_color_reg.blue;

endmodule

[rtl/nearest_palette_color.sv]
// top level of the nearest palette color block
// Maps a query color to the nearest of 16 palette entries by squared Euclidean
// distance, lowest index on ties; a load beat writes one entry and gives no
// response. The front end queues up to two request beats, so the request side
// keeps moving while the back end works. The back end takes a load in its idle
// state; for a query one shared difference, square and compare unit walks the
// palette one entry a cycle, then the unit drains its two-stage pipeline and the
// result is loaded into the response register once that register is free. The
// palette is zero after reset.
`include "nearest_palette_color_assert.svh"

module nearest_palette_color (
    input  logic        clk,
    input  logic        rst_n,
    npc_req_if.sink     req,
    npc_rsp_if.source   rsp
);

    npc_pkg::q_head_t       head;
    logic                   pop;
    npc_pkg::back_status_t  status;

    npc_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .head  (head),
        .pop   (pop)
    );

    npc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .status (status),
        .rsp    (rsp)
    );

    // a beat leaves the queue only when one is there and the back end is free
    `NPC_ASSERT_IMPLY(a_pop_has_head, pop, head.valid && !status.busy)
    // a query keeps the back end busy, so nothing else is popped next cycle
    `NPC_ASSERT_NEXT(a_query_blocks, pop && head.item.is_query, !pop && status.busy)
    // a response is loaded only into a free response register and then shows as valid
    `NPC_ASSERT_NEXT(a_emit_shows, status.emitting, rsp.valid)

endmodule

[tb/nearest_palette_color_tb.sv]
// testbench for the nearest palette color block: directed and random loads and queries
`timescale 1ns / 1ps

module nearest_palette_color_tb;

    typedef struct packed {
        logic [npc_pkg::IDX_W-1:0] index;
        npc_pkg::color_t           color;
    } match_t;

    logic clk = 1'b0;
    logic rst_n;

    npc_req_if req_bus ();
    npc_rsp_if rsp_bus ();

    nearest_palette_color dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    npc_pkg::color_t palette_model [0:npc_pkg::PALETTE_SIZE-1];
    match_t pending_matches [$];

    int n_loads   = 0;
    int n_queries = 0;
    int n_checked = 0;
    int n_errors  = 0;
    int req_calm  = 0;
    int rsp_calm  = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // wait cycles before a beat, with occasional stretches of back-to-back beats
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(8, 32);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic int sq_distance(input npc_pkg::color_t a, input npc_pkg::color_t b);
        int dr;
        int dg;
        int db;
        dr = int'(a.red) - int'(b.red);
        dg = int'(a.green) - int'(b.green);
        db = int'(a.blue) - int'(b.blue);
        return dr * dr + dg * dg + db * db;
    endfunction

    // strict less-than scan, so the lowest index keeps a tie
    function automatic match_t find_nearest(input npc_pkg::color_t probe);
        match_t best;
        int     best_d;
        int     d;
        best.index = '0;
        best.color = palette_model[0];
        best_d     = sq_distance(palette_model[0], probe);
        for (int i = 1; i < npc_pkg::PALETTE_SIZE; i++)
        begin
            d = sq_distance(palette_model[i], probe);
            if (d < best_d)
            begin
                best_d     = d;
                best.index = npc_pkg::IDX_W'(i);
                best.color = palette_model[i];
            end
        end
        return best;
    endfunction

    function automatic logic [npc_pkg::CH_W-1:0] clamp8(input int v);
        if (v < 0)
            return '0;
        if (v > 255)
            return '1;
        return npc_pkg::CH_W'(v);
    endfunction

    function automatic npc_pkg::color_t rgb(input int r, input int g, input int b);
        npc_pkg::color_t c;
        c.red   = npc_pkg::CH_W'(r);
        c.green = npc_pkg::CH_W'(g);
        c.blue  = npc_pkg::CH_W'(b);
        return c;
    endfunction

    task automatic send_beat(input npc_pkg::req_kind_t kind,
                             input logic [npc_pkg::IDX_W-1:0] slot,
                             input npc_pkg::color_t c);
        int gap;
        gap = draw_wait(req_calm);
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.req_type    <= kind;
        req_bus.entry_index <= slot;
        req_bus.red         <= c.red;
        req_bus.green       <= c.green;
        req_bus.blue        <= c.blue;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        if (kind == npc_pkg::REQ_LOAD)
        begin
            if (slot < npc_pkg::PALETTE_SIZE)
                palette_model[slot] = c;
            n_loads++;
        end
        else
        begin
            pending_matches.push_back(find_nearest(c));
            n_queries++;
        end
    endtask

    task automatic load_entry(input int slot, input npc_pkg::color_t c);
        send_beat(npc_pkg::REQ_LOAD, npc_pkg::IDX_W'(slot), c);
    endtask

    // entry_index is don't-care on a query, so it is randomized
    task automatic query_color(input npc_pkg::color_t c);
        send_beat(npc_pkg::REQ_QUERY, npc_pkg::IDX_W'($urandom), c);
    endtask

    task automatic test_empty_palette();
        query_color(rgb(8'h00, 8'h00, 8'h00));
        query_color(rgb(8'hff, 8'hff, 8'hff));
        query_color(rgb(8'h5a, 8'ha5, 8'h3c));
    endtask

    task automatic test_extremes();
        load_entry(15, rgb(8'hff, 8'hff, 8'hff));
        load_entry(0, rgb(8'h00, 8'h00, 8'h00));
        query_color(rgb(8'hff, 8'hff, 8'hff));
        query_color(rgb(8'h00, 8'h00, 8'h00));
        query_color(rgb(8'h80, 8'h80, 8'h80));
        load_entry(5, rgb(8'haa, 8'h55, 8'haa));
        load_entry(10, rgb(8'h55, 8'haa, 8'h55));
        query_color(rgb(8'haa, 8'h55, 8'haa));
        query_color(rgb(8'h50, 8'hb0, 8'h50));
    endtask

    task automatic test_ties();
        load_entry(4, rgb(8'h40, 8'h80, 8'hc0));
        load_entry(9, rgb(8'h40, 8'h80, 8'hc0));
        query_color(rgb(8'h40, 8'h80, 8'hc0));
        load_entry(2, rgb(8'h00, 8'h00, 8'h14));
        load_entry(3, rgb(8'h00, 8'h00, 8'h28));
        query_color(rgb(8'h00, 8'h00, 8'h1e));
        query_color(rgb(8'h00, 8'h00, 8'h0a));
    endtask

    task automatic test_random(input int count);
        int              pick;
        int              src;
        npc_pkg::color_t c;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            src  = $urandom_range(0, npc_pkg::PALETTE_SIZE - 1);
            c    = npc_pkg::color_t'(24'($urandom));
            if (pick < 30)
            begin
                if ($urandom_range(0, 7) == 0)
                    c = rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                            $urandom_range(0, 1) * 255);
                load_entry($urandom_range(0, npc_pkg::PALETTE_SIZE - 1), c);
            end
            else if (pick < 36)
            begin
                // duplicate an existing entry to force ties
                load_entry($urandom_range(0, npc_pkg::PALETTE_SIZE - 1), palette_model[src]);
            end
            else if (pick < 55)
            begin
                query_color(palette_model[src]);
            end
            else if (pick < 82)
            begin
                c.red   = clamp8(int'(palette_model[src].red) + $urandom_range(0, 12) - 6);
                c.green = clamp8(int'(palette_model[src].green) + $urandom_range(0, 12) - 6);
                c.blue  = clamp8(int'(palette_model[src].blue) + $urandom_range(0, 12) - 6);
                query_color(c);
            end
            else
            begin
                query_color(c);
            end
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endtask

    initial
    begin : rsp_drain
        match_t want;
        int     stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_wait(rsp_calm);
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid)
                @(posedge clk);
            if (pending_matches.size() == 0)
            begin
                $display("%0t ns: unexpected response beat, index %0d", $time,
                         rsp_bus.nearest_index);
                n_errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                report_field("nearest_index", want.index, rsp_bus.nearest_index);
                report_field("match_red", want.color.red, rsp_bus.match_red);
                report_field("match_green", want.color.green, rsp_bus.match_green);
                report_field("match_blue", want.color.blue, rsp_bus.match_blue);
                n_checked++;
            end
        end
    end

    initial
    begin
        #2ms;
        $display("timeout with %0d responses outstanding", pending_matches.size());
        $display("nearest_palette_color_tb: errors");
        $finish;
    end

    initial
    begin : main_seq
        int drain;
        rst_n               = 1'b0;
        req_bus.valid       = 1'b0;
        req_bus.req_type    = npc_pkg::REQ_LOAD;
        req_bus.entry_index = '0;
        req_bus.red         = '0;
        req_bus.green       = '0;
        req_bus.blue        = '0;
        rsp_bus.ready       = 1'b0;
        for (int i = 0; i < npc_pkg::PALETTE_SIZE; i++)
            palette_model[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_palette();
        test_extremes();
        test_ties();
        test_random(950);
        req_bus.valid <= 1'b0;

        drain = 0;
        while (pending_matches.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (40) @(posedge clk);
        if (pending_matches.size() != 0)
        begin
            $display("%0t ns: %0d expected responses never arrived", $time,
                     pending_matches.size());
            n_errors++;
        end

        $display("covered %0d palette loads and %0d nearest color queries", n_loads, n_queries);
        $display("%0d response beats checked, %0d mismatches", n_checked, n_errors);
        if (n_errors == 0)
            $display("nearest_palette_color_tb: clean");
        else
            $display("nearest_palette_color_tb: errors");
        $finish;
    end

endmodule
